@@ rtl/pfr_pkg.sv @@
// ============================================================================
// pfr_pkg
// Shared types and constants for the paced FIFO release block.
// ============================================================================
package pfr_pkg;

    localparam int TAG_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int INTERVAL_W = 16;
    localparam int KIND_W     = 2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5;
    localparam logic [INTERVAL_W-1:0] COUNT_ONE      = 16'd1;

    // Item kinds; the fourth code is ignored
    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   word_tag;
        logic [VALUE_W-1:0] word_value;
    } item_t;

    typedef struct packed {
        logic               out_valid;
        logic [TAG_W-1:0]   out_tag;
        logic [VALUE_W-1:0] out_value;
        logic               empty_event;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

@@ rtl/paced_fifo_release.sv @@
// ============================================================================
// paced_fifo_release
// Rate-limited FIFO that releases tagged data words at a steady pace.
// ============================================================================
// Usage:
//   item channel (item_valid / item_stall / item): one beat is a push, a
//   tick or a clear. Pushes while idle pass straight out and arm the
//   countdown; later pushes queue in a ring held in one synchronous RAM.
//   Each tick counts down; on expiry the head word is released.
//   result channel (result_valid / result_stall / result): zero or one beat
//   per item, in item order. Items that give no result (queued push, plain
//   tick, clear) leave nothing on this channel.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes release_interval;
//   always ready, a zero write is dropped. Write only while no beat is in
//   flight; a new value applies when the countdown next restarts.
// Throughput: one item per cycle while item_stall is low. Control state
//   (pointers, countdown, idle) is updated in the accept cycle; the RAM sees
//   at most one write (push) or one read (release) per item, never both.
// Result path: a result beat passes through the RAM read stage, then the
//   output register, before it is presented.
// Stall: the read stage and the output register form two slots, so an item
//   is still taken while a finished result waits. item_stall rises only when
//   both slots are full and result_stall is high.
// Reset: pointers and countdown clear, the block goes idle, release_interval
//   returns to 5. The ring RAM is not cleared; only written entries are read.
// ============================================================================
module paced_fifo_release #(
    parameter int RING_DEPTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  pfr_pkg::item_t                item,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output pfr_pkg::result_t              result,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfr_pkg::INTERVAL_W-1:0] cfg_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    // Advance a ring index with wrap at the last slot
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              tail_reg, tail_next;
    logic                          idle_reg, idle_next;
    logic [pfr_pkg::INTERVAL_W-1:0] countdown_reg, countdown_next;
    logic [pfr_pkg::INTERVAL_W-1:0] interval_reg;

    // Read stage: the result under construction while the RAM read is in flight
    logic                          s1_valid_reg;
    logic                          s1_from_mem_reg;
    pfr_pkg::result_t              s1_res_reg;

    // Output register
    logic                          res_valid_reg;
    pfr_pkg::result_t              res_reg;

    // Ring RAM
    pfr_pkg::entry_t               ring_mem [RING_DEPTH];
    pfr_pkg::entry_t               rd_data_reg;

    logic                          item_fire;
    logic                          out_free;
    logic                          s1_advance;
    logic                          wr_en;
    logic                          rd_en;
    logic                          s1_load;
    pfr_pkg::result_t              s1_load_res;
    pfr_pkg::result_t              merged_res;
    logic [PTR_W-1:0]              tail_inc;
    logic [PTR_W-1:0]              head_inc;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    assign out_free     = !res_valid_reg || !result_stall;
    assign s1_advance   = s1_valid_reg && out_free;
    assign item_stall   = s1_valid_reg && !out_free;
    assign item_fire    = item_valid && !item_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

    assign tail_inc = ring_next(tail_reg);
    assign head_inc = ring_next(head_reg);

    // ------------------------------------------------------------------------
    // Item decode: update control state and schedule the RAM access
    // ------------------------------------------------------------------------
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        idle_next      = idle_reg;
        countdown_next = countdown_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        s1_load        = 1'b0;
        s1_load_res    = '0;

        if (item_fire)
        begin
            unique case (item.kind)
                pfr_pkg::KIND_PUSH:
                begin
                    if (idle_reg)
                    begin
                        // Pass straight out and arm the countdown
                        idle_next             = 1'b0;
                        countdown_next        = interval_reg;
                        s1_load               = 1'b1;
                        s1_load_res.out_valid = 1'b1;
                        s1_load_res.out_tag   = item.word_tag;
                        s1_load_res.out_value = item.word_value;
                    end
                    else if (tail_inc == head_reg)
                    begin
                        // Ring full: drop the word and flag it
                        s1_load              = 1'b1;
                        s1_load_res.overflow = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        tail_next = tail_inc;
                    end
                end
                pfr_pkg::KIND_TICK:
                begin
                    if (!idle_reg)
                    begin
                        if (countdown_reg > pfr_pkg::COUNT_ONE)
                        begin
                            countdown_next = countdown_reg - pfr_pkg::COUNT_ONE;
                        end
                        else
                        begin
                            countdown_next = '0;
                            s1_load        = 1'b1;
                            if (head_reg == tail_reg)
                            begin
                                idle_next               = 1'b1;
                                s1_load_res.empty_event = 1'b1;
                            end
                            else
                            begin
                                // Release the head word; data arrives next cycle
                                rd_en                 = 1'b1;
                                head_next             = head_inc;
                                s1_load_res.out_valid = 1'b1;
                                if (head_inc == tail_reg)
                                begin
                                    idle_next               = 1'b1;
                                    s1_load_res.empty_event = 1'b1;
                                end
                                else
                                begin
                                    countdown_next = interval_reg;
                                end
                            end
                        end
                    end
                end
                pfr_pkg::KIND_CLEAR:
                begin
                    tail_next      = head_reg;
                    idle_next      = 1'b1;
                    countdown_next = '0;
                end
                default:
                begin
                    // Unused kind: ignore
                end
            endcase
        end
    end

    // Fill in the released word from the RAM read data
    always_comb
    begin
        merged_res = s1_res_reg;
        if (s1_from_mem_reg)
        begin
            merged_res.out_tag   = rd_data_reg.tag;
            merged_res.out_value = rd_data_reg.value;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            idle_reg      <= 1'b1;
            countdown_reg <= '0;
            interval_reg  <= pfr_pkg::INTERVAL_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            idle_reg      <= idle_next;
            countdown_reg <= countdown_next;
            if (cfg_valid && cfg_ready && (cfg_data != '0))
            begin
                interval_reg <= cfg_data;
            end
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_res_reg      <= s1_load_res;
            s1_from_mem_reg <= rd_en;
        end
        if (s1_advance)
        begin
            res_reg <= merged_res;
        end
    end

    // Ring RAM: one write port at the tail, one registered read port at the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[tail_reg] <= '{tag: item.word_tag, value: item.word_value};
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[head_reg];
        end
    end

`ifndef SYNTHESIS
    // Idle means the ring is empty and the timer stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg |-> (head_reg == tail_reg) && (countdown_reg == '0))
        else $error("idle with queued words or a running countdown");

    // A RAM read always lands in the read stage as a release
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> s1_valid_reg && s1_from_mem_reg && s1_res_reg.out_valid)
        else $error("RAM read not tracked by the read stage");

    // Never accept an item that would overwrite a held read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> !item_fire)
        else $error("read stage overwritten while held");

    // A beat without a released word carries a zero tag and value
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.out_valid) |->
            (res_reg.out_tag == '0) && (res_reg.out_value == '0))
        else $error("stray payload on a flag-only beat");
`endif

endmodule

@@ sim/tb_paced_fifo_release.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_paced_fifo_release
// Self-checking testbench for the paced FIFO release block.
// A predictor follows every accepted item beat and queues the result beat
// it should cause. Each result beat is checked field by field against the
// oldest queued expectation. The run covers the corner cases first, then a
// long receiver hold-off and random phases across several release intervals.
// ============================================================================
module tb_paced_fifo_release;

    localparam int RING_WORDS      = 2048;
    localparam int WATCHDOG_LIMIT  = 3000;   // well above hold-off plus gaps
    localparam int SETTLE_CYCLES   = 6;      // covers the read stage and output register
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 160;

    // The fourth kind code has no meaning and must be ignored
    localparam logic [pfr_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    // Word type tags; the fourth is carried unchanged
    localparam logic [pfr_pkg::TAG_W-1:0] TAG_INT    = 2'd0;
    localparam logic [pfr_pkg::TAG_W-1:0] TAG_FLOAT  = 2'd1;
    localparam logic [pfr_pkg::TAG_W-1:0] TAG_SYMBOL = 2'd2;
    localparam logic [pfr_pkg::TAG_W-1:0] TAG_SPARE  = 2'd3;

    // Idling styles for either side of the block
    localparam int PACE_NONE  = 0;
    localparam int PACE_LIGHT = 1;
    localparam int PACE_HEAVY = 2;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid;
    logic                           item_stall;
    pfr_pkg::item_t                 item;
    logic                           result_valid;
    logic                           result_stall;
    pfr_pkg::result_t               result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [pfr_pkg::INTERVAL_W-1:0] cfg_data;

    // Predicted state of the block
    pfr_pkg::entry_t                ring_model[$];
    bit                             model_running;
    int unsigned                    model_count;
    logic [pfr_pkg::INTERVAL_W-1:0] model_interval;

    // Result beats still owed by the block, oldest first
    pfr_pkg::result_t               due_results[$];
    pfr_pkg::result_t               want_result;

    int errors;
    int result_beats;
    int idle_cycles;
    int tx_pace;
    int rx_pace;
    int stall_left;
    int hold_left;

    paced_fifo_release #(
        .RING_DEPTH (RING_WORDS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Cycles to idle before the next beat on one side
    function automatic int draw_gap(int pace);
        if (pace == PACE_NONE)
            return 0;
        if (pace == PACE_LIGHT)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic pfr_pkg::item_t word_item(logic [pfr_pkg::KIND_W-1:0] k,
                                                 logic [pfr_pkg::TAG_W-1:0] tag,
                                                 logic [pfr_pkg::VALUE_W-1:0] value);
        pfr_pkg::item_t it;
        it.kind       = k;
        it.word_tag   = tag;
        it.word_value = value;
        return it;
    endfunction

    // Tag and payload are random even where the kind ignores them
    function automatic pfr_pkg::item_t random_item(logic [pfr_pkg::KIND_W-1:0] k);
        return word_item(k, pfr_pkg::TAG_W'($urandom_range(0, 3)),
                         pfr_pkg::VALUE_W'($urandom));
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [pfr_pkg::VALUE_W-1:0] got,
                               logic [pfr_pkg::VALUE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                      result_beats, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Predictor: advance the model by one accepted item beat and queue the
    // result beat it causes, if any.
    // ------------------------------------------------------------------------
    function automatic void predict_release(pfr_pkg::item_t it);
        pfr_pkg::result_t r;
        pfr_pkg::entry_t  e;
        r = '0;
        unique case (it.kind)
            pfr_pkg::KIND_PUSH:
            begin
                if (!model_running)
                begin
                    // Idle: the word passes straight out and arms the countdown
                    model_running = 1'b1;
                    model_count   = 32'(model_interval);
                    r.out_valid   = 1'b1;
                    r.out_tag     = it.word_tag;
                    r.out_value   = it.word_value;
                    due_results.push_back(r);
                end
                else if (ring_model.size() == RING_WORDS - 1)
                begin
                    // Ring full: drop the word and flag it
                    r.overflow = 1'b1;
                    due_results.push_back(r);
                end
                else
                begin
                    e.tag   = it.word_tag;
                    e.value = it.word_value;
                    ring_model.push_back(e);
                end
            end
            pfr_pkg::KIND_TICK:
            begin
                if (model_running)
                begin
                    if (model_count > 1)
                        model_count--;
                    else
                    begin
                        model_count = 0;
                        if (ring_model.size() == 0)
                        begin
                            // Expiry after a lone pass-through word
                            model_running = 1'b0;
                            r.empty_event = 1'b1;
                        end
                        else
                        begin
                            e           = ring_model.pop_front();
                            r.out_valid = 1'b1;
                            r.out_tag   = e.tag;
                            r.out_value = e.value;
                            if (ring_model.size() == 0)
                            begin
                                model_running = 1'b0;
                                r.empty_event = 1'b1;
                            end
                            else
                                model_count = 32'(model_interval);
                        end
                        due_results.push_back(r);
                    end
                end
            end
            pfr_pkg::KIND_CLEAR:
            begin
                ring_model.delete();
                model_running = 1'b0;
                model_count   = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle for a drawn number of cycles, present the beat at the
    // falling edge and hold it until taken. Returns just after the taking
    // edge with valid still high, so the next call either replaces the
    // payload or drops valid at the following falling edge.
    // ------------------------------------------------------------------------
    task automatic send_item(pfr_pkg::item_t it);
        int gap;
        gap = draw_gap(tx_pace);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict_release(it);
    endtask

    // Drop valid, wait for every owed beat, then let in-flight items that
    // give no result leave the pipeline.
    task automatic settle_block();
        @(negedge clk);
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called once the block has settled
    task automatic write_interval(logic [pfr_pkg::INTERVAL_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (value != '0)
            model_interval = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: drive stall at the falling edge. A hold-off set by a test
    // takes priority over the per-beat gaps.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            result_beats++;
            stall_left = draw_gap(rx_pace);
            if (due_results.size() == 0)
                report_mismatch($sformatf("beat %0d: result with nothing expected",
                                          result_beats));
            else
            begin
                want_result = due_results.pop_front();
                check_field("out_valid", pfr_pkg::VALUE_W'(result.out_valid),
                            pfr_pkg::VALUE_W'(want_result.out_valid));
                check_field("out_tag", pfr_pkg::VALUE_W'(result.out_tag),
                            pfr_pkg::VALUE_W'(want_result.out_tag));
                check_field("out_value", result.out_value, want_result.out_value);
                check_field("empty_event", pfr_pkg::VALUE_W'(result.empty_event),
                            pfr_pkg::VALUE_W'(want_result.empty_event));
                check_field("overflow", pfr_pkg::VALUE_W'(result.overflow),
                            pfr_pkg::VALUE_W'(want_result.overflow));
            end
        end
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases with known words, first at the reset interval of five
    task automatic test_directed_cases();
        tx_pace = PACE_LIGHT;
        rx_pace = PACE_LIGHT;
        // Tick and spare kind while idle: no result
        send_item(random_item(pfr_pkg::KIND_TICK));
        send_item(random_item(KIND_SPARE));
        // Pass-through, then expiry with an empty ring after five ticks
        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_INT, 32'h0000_0000));
        repeat (5) send_item(random_item(pfr_pkg::KIND_TICK));
        settle_block();

        // A zero write must leave the interval alone
        write_interval('0);
        write_interval(16'd2);

        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_FLOAT, 32'hFFFF_FFFF));
        // Queue a word with the unused tag and one with the top bit only
        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_SPARE, 32'h0000_0001));
        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_SYMBOL, 32'h8000_0000));
        repeat (2) send_item(random_item(pfr_pkg::KIND_TICK));
        // Last queued word goes out together with the empty flag
        repeat (2) send_item(random_item(pfr_pkg::KIND_TICK));
        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_SYMBOL, 32'hA5A5_5A5A));
        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_FLOAT, 32'h1234_5678));
        // Clear a non-empty ring: silent, and the block goes idle
        send_item(random_item(pfr_pkg::KIND_CLEAR));
        send_item(random_item(pfr_pkg::KIND_TICK));
        send_item(word_item(pfr_pkg::KIND_PUSH, TAG_SPARE, 32'h7FFF_FFFF));
        settle_block();
    endtask

    // Hold the result side off while every item gives a beat, so both
    // output slots fill and the block stalls its input
    task automatic test_backpressure();
        write_interval(16'd1);
        tx_pace = PACE_NONE;
        rx_pace = PACE_NONE;
        send_item(random_item(pfr_pkg::KIND_CLEAR));
        hold_left = HOLD_OFF_CYCLES;
        repeat (30)
        begin
            send_item(random_item(pfr_pkg::KIND_PUSH));
            send_item(random_item(pfr_pkg::KIND_TICK));
        end
        settle_block();
    endtask

    // Random phases, each at its own interval and idling style
    task automatic test_random_traffic();
        int                             phase;
        int                             n;
        int                             r;
        int                             push_pct;
        int                             clear_pct;
        logic [pfr_pkg::INTERVAL_W-1:0] interval;
        for (phase = 0; phase < PHASES; phase++)
        begin
            unique case (phase)
                0:       interval = 16'd1;
                1:       interval = 16'hFFFF;
                2:       interval = pfr_pkg::INTERVAL_W'($urandom_range(2, 4));
                3:       interval = pfr_pkg::INTERVAL_W'($urandom_range(20, 60));
                default: interval = pfr_pkg::INTERVAL_W'($urandom_range(1, 12));
            endcase
            write_interval(interval);
            if (phase == 0)
            begin
                tx_pace = PACE_NONE;
                rx_pace = PACE_NONE;
            end
            else
            begin
                tx_pace = $urandom_range(PACE_NONE, PACE_HEAVY);
                rx_pace = $urandom_range(PACE_NONE, PACE_HEAVY);
            end
            // Balance pushes against ticks so words keep flowing out
            push_pct  = 100 / (interval + 1);
            push_pct  = (push_pct < 5) ? 5 : push_pct;
            // Long intervals rarely expire; clear often to get pass-through
            clear_pct = (interval > 100) ? 12 : 2;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < clear_pct)
                    send_item(random_item(pfr_pkg::KIND_CLEAR));
                else if (r < clear_pct + 2)
                    send_item(random_item(KIND_SPARE));
                else if ($urandom_range(0, 99) < push_pct)
                    send_item(random_item(pfr_pkg::KIND_PUSH));
                else
                    send_item(random_item(pfr_pkg::KIND_TICK));
            end
            settle_block();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        result_stall   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        errors         = 0;
        result_beats   = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        hold_left      = 0;
        tx_pace        = PACE_NONE;
        rx_pace        = PACE_NONE;
        model_running  = 1'b0;
        model_count    = 0;
        model_interval = pfr_pkg::INTERVAL_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_traffic();

        settle_block();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
